### rtl/core/uqp_pkg.sv
// Shared types, character codes and helper functions of the query string decoder.
package uqp_pkg;

  // Most result items that one input item can cause.
  localparam int MAX_RESULTS = 4;
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // Default depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;

  // Characters with a special meaning in the query string.
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_AMP   = 8'h26;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_F  = 8'h46;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_F  = 8'h66;

  // Letters decode to their low nibble plus this offset.
  localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

  // Tag of a result item.
  typedef enum logic [1:0] {
    KIND_KEY      = 2'd0,
    KIND_VALUE    = 2'd1,
    KIND_PAIR_END = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
  } result_t;

  // All results of one input item, in order, with their count.
  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [RES_CNT_W-1:0]      count;
  } bundle_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Decode one hex digit of either case.
  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      h.ok  = 1'b1;
      h.val = c[3:0];
    end else if ((c >= CHAR_UC_A && c <= CHAR_UC_F) || (c >= CHAR_LC_A && c <= CHAR_LC_F)) begin
      h.ok  = 1'b1;
      h.val = c[3:0] + HEX_LETTER_OFS;
    end
    return h;
  endfunction

  // Append one result to a bundle; a full bundle stays as it is.
  function automatic bundle_t push_result(bundle_t b, logic [7:0] d, kind_e k);
    bundle_t r;
    r = b;
    if (b.count < RES_CNT_W'(MAX_RESULTS)) begin
      r.res[b.count[RES_IDX_W-1:0]].data = d;
      r.res[b.count[RES_IDX_W-1:0]].kind = k;
      r.count = b.count + RES_CNT_W'(1);
    end
    return r;
  endfunction

endpackage

### rtl/core/uqp_if.sv
// Channel interfaces of the query string decoder: raw bytes in, decoded items out.
interface uqp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       byte_present;
  logic       end_of_string;

  modport source (output valid, byte_in, byte_present, end_of_string, input ready);
  modport sink (input valid, byte_in, byte_present, end_of_string, output ready);
  modport monitor (input valid, ready, byte_in, byte_present, end_of_string);
endinterface

interface uqp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] decoded_byte;
  logic [1:0] item_kind;
  logic       run_last;

  modport source (output valid, decoded_byte, item_kind, run_last, input ready);
  modport sink (input valid, decoded_byte, item_kind, run_last, output ready);
  modport monitor (input valid, ready, decoded_byte, item_kind, run_last);
endinterface

### rtl/core/uqp_front.sv
// Front part: accepts raw bytes, tracks parse state and builds the results of each item.
module uqp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  uqp_in_if.sink             in_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output uqp_pkg::bundle_t   push_data_o
);

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_PCT  = 2'd1,
    ESC_HEX1 = 2'd2
  } stage_e;

  logic       phase_q, phase_d;
  logic       started_q, started_d;
  stage_e     stage_q, stage_d;
  logic [7:0] held_q, held_d;

  uqp_pkg::bundle_t bnd;
  uqp_pkg::hex_t    hex_in;
  uqp_pkg::hex_t    hex_held;
  logic             accept;

  // Give out a pending escape as literal bytes of the current phase.
  function automatic uqp_pkg::bundle_t release_esc(uqp_pkg::bundle_t b, stage_e s,
                                                   logic [7:0] held, uqp_pkg::kind_e k);
    uqp_pkg::bundle_t r;
    r = b;
    unique case (s)
      ESC_PCT: begin
        r = uqp_pkg::push_result(r, uqp_pkg::CHAR_PCT, k);
      end
      ESC_HEX1: begin
        r = uqp_pkg::push_result(r, uqp_pkg::CHAR_PCT, k);
        r = uqp_pkg::push_result(r, held, k);
      end
      default: begin
        r = b;
      end
    endcase
    return r;
  endfunction

  assign hex_in   = uqp_pkg::hex_decode(in_i.byte_in);
  assign hex_held = uqp_pkg::hex_decode(held_q);

  // Work out the results of the offered item and the state that it leaves.
  always_comb begin
    bnd       = '0;
    phase_d   = phase_q;
    started_d = started_q;
    held_d    = held_q;
    stage_d   = (stage_q == ESC_PCT || stage_q == ESC_HEX1) ? stage_q : ESC_NONE;

    if (in_i.byte_present) begin
      if (stage_d == ESC_PCT && hex_in.ok) begin
        held_d  = in_i.byte_in;
        stage_d = ESC_HEX1;
      end else if (stage_d == ESC_HEX1 && hex_in.ok) begin
        bnd = uqp_pkg::push_result(bnd, {hex_held.val, hex_in.val},
                                   phase_d ? uqp_pkg::KIND_VALUE : uqp_pkg::KIND_KEY);
        stage_d = ESC_NONE;
      end else begin
        // A broken escape goes out literally before the byte itself.
        bnd = release_esc(bnd, stage_d, held_d,
                          phase_d ? uqp_pkg::KIND_VALUE : uqp_pkg::KIND_KEY);
        stage_d = ESC_NONE;
        if (in_i.byte_in == uqp_pkg::CHAR_AMP) begin
          if (started_d) begin
            bnd = uqp_pkg::push_result(bnd, 8'h00, uqp_pkg::KIND_PAIR_END);
          end
          started_d = 1'b0;
          phase_d   = 1'b0;
        end else begin
          started_d = 1'b1;
          if (in_i.byte_in == uqp_pkg::CHAR_EQ && !phase_d) begin
            phase_d = 1'b1;
          end else if (in_i.byte_in == uqp_pkg::CHAR_PLUS) begin
            bnd = uqp_pkg::push_result(bnd, uqp_pkg::CHAR_SPACE,
                                       phase_d ? uqp_pkg::KIND_VALUE : uqp_pkg::KIND_KEY);
          end else if (in_i.byte_in == uqp_pkg::CHAR_PCT) begin
            stage_d = ESC_PCT;
          end else begin
            bnd = uqp_pkg::push_result(bnd, in_i.byte_in,
                                       phase_d ? uqp_pkg::KIND_VALUE : uqp_pkg::KIND_KEY);
          end
        end
      end
    end

    // End of string flushes the escape, closes the part and clears all state.
    if (in_i.end_of_string) begin
      bnd = release_esc(bnd, stage_d, held_d,
                        phase_d ? uqp_pkg::KIND_VALUE : uqp_pkg::KIND_KEY);
      if (started_d) begin
        bnd = uqp_pkg::push_result(bnd, 8'h00, uqp_pkg::KIND_PAIR_END);
      end
      phase_d   = 1'b0;
      started_d = 1'b0;
      stage_d   = ESC_NONE;
      held_d    = 8'h00;
    end
  end

  // Items that cause no result are taken without a queue entry.
  assign accept       = in_i.valid && push_ready_i;
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid && (bnd.count != '0);
  assign push_data_o  = bnd;

  // Parse state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= 1'b0;
      started_q <= 1'b0;
      stage_q   <= ESC_NONE;
      held_q    <= 8'h00;
    end else if (accept) begin
      phase_q   <= phase_d;
      started_q <= started_d;
      stage_q   <= stage_d;
      held_q    <= held_d;
    end
  end

endmodule

### rtl/core/uqp_queue.sv
// Short queue of result bundles between the front and back parts.
module uqp_queue #(
  parameter int QueueDepth = uqp_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  uqp_pkg::bundle_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output uqp_pkg::bundle_t pop_data_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  uqp_pkg::bundle_t mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

### rtl/core/uqp_back.sv
// Back part: takes one bundle at a time and hands its results out one item per cycle while out_o is ready.
module uqp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  uqp_pkg::bundle_t pop_data_i,
  uqp_out_if.source        out_o
);

  uqp_pkg::bundle_t                  bundle_q;
  logic [uqp_pkg::RES_IDX_W-1:0]     idx_q;
  logic                              valid_q;
  logic                              is_last;
  logic                              finish;
  logic                              load;

  assign is_last     = (uqp_pkg::RES_CNT_W'(idx_q) + uqp_pkg::RES_CNT_W'(1)) == bundle_q.count;
  assign finish      = valid_q && out_o.ready && is_last;
  assign pop_ready_o = !valid_q || finish;
  assign load        = pop_valid_i && pop_ready_o;

  assign out_o.valid        = valid_q;
  assign out_o.decoded_byte = bundle_q.res[idx_q].data;
  assign out_o.item_kind    = bundle_q.res[idx_q].kind;
  assign out_o.run_last     = is_last;

  // Bundle register and position within it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      idx_q    <= '0;
      bundle_q <= '0;
    end else if (load) begin
      valid_q  <= 1'b1;
      idx_q    <= '0;
      bundle_q <= pop_data_i;
    end else if (finish) begin
      valid_q <= 1'b0;
    end else if (valid_q && out_o.ready) begin
      idx_q <= idx_q + uqp_pkg::RES_IDX_W'(1);
    end
  end

endmodule

### rtl/core/urlencoded_query_parser_top.sv
// Top level of the streaming query string decoder.
//
//   Channel | Dir | Item
//   in_i    | in  | byte_in[7:0], byte_present, end_of_string
//   out_o   | out | decoded_byte[7:0], item_kind[1:0], run_last
//
// Input items are taken one per cycle while the result queue has room.
// The back part hands out one result item per cycle while out_o is ready, so
// an item's results leave in order; the single output port sets the sustained rate.
// Results go through the queue and then the back part's bundle register to the output.
// Reset is asynchronous and active low; it clears parse state, queue and output.
// Either side may stall at any time; the queue lets the input run ahead.
module urlencoded_query_parser_top #(
  parameter int QueueDepth = uqp_pkg::QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  uqp_in_if.sink   in_i,
  uqp_out_if.source out_o
);

  logic             push_valid, push_ready;
  logic             pop_valid, pop_ready;
  uqp_pkg::bundle_t push_data, pop_data;

  // Parse and classify.
  uqp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Decouple the two parts.
  uqp_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Serialize results.
  uqp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule

### rtl/core/uqp_checker.sv
// Assertions on the output channel of the decoder, bound to the top level.
module uqp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_data_i,
  input logic [1:0] out_kind_i,
  input logic       out_last_i
);

  // A stalled output item holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i)
      && $stable(out_kind_i) && $stable(out_last_i))
    else $error("output item changed while stalled");

  // A pair-end marker carries a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == uqp_pkg::KIND_PAIR_END |-> out_data_i == 8'h00)
    else $error("pair-end marker with nonzero byte");

  // Nothing follows a pair-end marker within the results of one input item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == uqp_pkg::KIND_PAIR_END |-> out_last_i)
    else $error("pair-end marker is not the last result of its item");

  // No output item while reset is applied.
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

endmodule

bind urlencoded_query_parser_top uqp_checker u_uqp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.decoded_byte),
  .out_kind_i  (out_o.item_kind),
  .out_last_i  (out_o.run_last)
);

### tb/urlencoded_query_parser_top_tb.sv
// Testbench of the query string decoder: random and directed strings, predicted results.
module urlencoded_query_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One decoded result as the output channel should carry it.
  typedef struct {
    logic [7:0]      data;
    uqp_pkg::kind_e  kind;
    bit              closes_run;
  } decoded_t;

  // Tracks the decoder state and holds the decoded items still owed by the block.
  class query_decode_tracker;
    bit          value_phase;
    bit          part_open;
    logic [1:0]  esc_stage;
    logic [7:0]  held_digit;
    decoded_t    step_out[$];
    decoded_t    owed_q[$];
    int unsigned fail_count;

    function new();
      clear_state();
      fail_count = 0;
    endfunction

    function void clear_state();
      value_phase = 1'b0;
      part_open   = 1'b0;
      esc_stage   = 2'd0;
      held_digit  = 8'h00;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Value of a hex digit of either case, or -1 for any other byte.
    function int hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      return -1;
    endfunction

    function void add_result(logic [7:0] d, uqp_pkg::kind_e k);
      decoded_t r;
      r.data       = d;
      r.kind       = k;
      r.closes_run = 1'b0;
      if (step_out.size() < uqp_pkg::MAX_RESULTS) step_out.push_back(r);
    endfunction

    function void add_data(logic [7:0] d);
      add_result(d, value_phase ? uqp_pkg::KIND_VALUE : uqp_pkg::KIND_KEY);
    endfunction

    // A pending escape that cannot complete comes out as literal bytes.
    function void flush_escape();
      if (esc_stage == 2'd1) begin
        add_data(uqp_pkg::CHAR_PCT);
      end else if (esc_stage == 2'd2) begin
        add_data(uqp_pkg::CHAR_PCT);
        add_data(held_digit);
      end
      esc_stage = 2'd0;
    endfunction

    function void plain_byte(logic [7:0] b);
      if (b == uqp_pkg::CHAR_AMP) begin
        if (part_open) add_result(8'h00, uqp_pkg::KIND_PAIR_END);
        part_open   = 1'b0;
        value_phase = 1'b0;
        return;
      end
      part_open = 1'b1;
      if (b == uqp_pkg::CHAR_EQ && !value_phase) begin
        value_phase = 1'b1;
      end else if (b == uqp_pkg::CHAR_PLUS) begin
        add_data(uqp_pkg::CHAR_SPACE);
      end else if (b == uqp_pkg::CHAR_PCT) begin
        esc_stage = 2'd1;
      end else begin
        add_data(b);
      end
    endfunction

    function void take_byte(logic [7:0] b);
      int d;
      int hi;
      logic [3:0] hi_nib;
      d = hex_value(b);
      if (esc_stage == 2'd1 && d >= 0) begin
        held_digit = b;
        esc_stage  = 2'd2;
        return;
      end
      if (esc_stage == 2'd2 && d >= 0) begin
        hi     = hex_value(held_digit);
        hi_nib = (hi < 0) ? 4'd0 : hi[3:0];
        add_data({hi_nib, d[3:0]});
        esc_stage = 2'd0;
        return;
      end
      flush_escape();
      plain_byte(b);
    endfunction

    // Work out the results of one accepted input item and queue them.
    function void note_input(logic [7:0] b, logic present, logic eos);
      step_out.delete();
      if (present) take_byte(b);
      if (eos) begin
        flush_escape();
        if (part_open) add_result(8'h00, uqp_pkg::KIND_PAIR_END);
        clear_state();
      end
      if (step_out.size() > 0) step_out[step_out.size()-1].closes_run = 1'b1;
      foreach (step_out[i]) owed_q.push_back(step_out[i]);
    endfunction

    task report_mismatch(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      fail_count++;
    endtask

    // Compare one accepted result with the oldest owed one.
    task check_result(logic [7:0] d, logic [1:0] k, logic run_last);
      decoded_t e;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result data=%h kind=%0d last=%0d", d, k, run_last));
        return;
      end
      e = owed_q.pop_front();
      if (d !== e.data)
        report_mismatch($sformatf("decoded_byte %h, expected %h", d, e.data));
      if (k !== e.kind)
        report_mismatch($sformatf("item_kind %0d, expected %0d", k, e.kind));
      if (run_last !== e.closes_run)
        report_mismatch($sformatf("run_last %0d, expected %0d", run_last, e.closes_run));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  uqp_in_if  in_if ();
  uqp_out_if out_if ();

  urlencoded_query_parser_top i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  query_decode_tracker board = new();

  bit          tx_idle_en;
  bit          rx_idle_en;
  bit          hold_request;
  int unsigned items_sent;
  logic [7:0]  query_buf[$];

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watch both channels and feed the tracker.
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready)
      board.note_input(in_if.byte_in, in_if.byte_present, in_if.end_of_string);
    if (rst_ni && out_if.valid && out_if.ready)
      board.check_result(out_if.decoded_byte, out_if.item_kind, out_if.run_last);
  end

  // Receiver: random stalls per item, and one long hold-off on request.
  initial begin
    int gap;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        out_if.ready <= 1'b0;
        repeat (60) @(posedge clk_i);
        hold_request = 1'b0;
      end
      gap = rx_idle_en ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // Offer one input item after a random gap and wait until it is taken.
  task send_item(logic [7:0] b, logic present, logic eos);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.byte_in       <= b;
    in_if.byte_present  <= present;
    in_if.end_of_string <= eos;
    do @(posedge clk_i); while (!in_if.ready);
    if (present || eos) items_sent++;
  endtask

  task send_text(string s, bit end_flag);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], 1'b1, end_flag && (i == s.len() - 1));
  endtask

  function logic [7:0] rand_hex();
    case ($urandom_range(0, 2))
      0:       return 8'(int'("0") + $urandom_range(0, 9));
      1:       return 8'(int'("A") + $urandom_range(0, 5));
      default: return 8'(int'("a") + $urandom_range(0, 5));
    endcase
  endfunction

  // A byte that ends an escape early: a non-hex letter or a special character.
  function logic [7:0] rand_non_hex();
    case ($urandom_range(0, 5))
      0:       return uqp_pkg::CHAR_AMP;
      1:       return uqp_pkg::CHAR_EQ;
      2:       return uqp_pkg::CHAR_PLUS;
      3:       return uqp_pkg::CHAR_PCT;
      default: return 8'(int'("g") + $urandom_range(0, 19));
    endcase
  endfunction

  // Append one token of a key or value to the query.
  function void add_token();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      query_buf.push_back($urandom_range(0, 1) ? 8'(int'("a") + $urandom_range(0, 25))
                                               : 8'(int'("0") + $urandom_range(0, 9)));
    end else if (r < 55) begin
      query_buf.push_back(uqp_pkg::CHAR_PLUS);
    end else if (r < 75) begin
      query_buf.push_back(uqp_pkg::CHAR_PCT);
      query_buf.push_back(rand_hex());
      query_buf.push_back(rand_hex());
    end else if (r < 82) begin
      query_buf.push_back(uqp_pkg::CHAR_PCT);
      if ($urandom_range(0, 1)) query_buf.push_back(rand_hex());
      query_buf.push_back(rand_non_hex());
    end else if (r < 90) begin
      query_buf.push_back(uqp_pkg::CHAR_EQ);
    end else begin
      query_buf.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // Build one query string: mostly key=value parts, sometimes raw noise.
  function void make_query();
    int nparts;
    query_buf.delete();
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 8)) query_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    nparts = $urandom_range(1, 4);
    for (int p = 0; p < nparts; p++) begin
      if (p > 0) query_buf.push_back(uqp_pkg::CHAR_AMP);
      if ($urandom_range(0, 9) == 0) query_buf.push_back(uqp_pkg::CHAR_AMP);
      repeat ($urandom_range(0, 4)) add_token();
      if ($urandom_range(0, 4) != 0) query_buf.push_back(uqp_pkg::CHAR_EQ);
      repeat ($urandom_range(0, 5)) add_token();
    end
    // Leave an escape open at the end now and then.
    if ($urandom_range(0, 9) == 0) begin
      query_buf.push_back(uqp_pkg::CHAR_PCT);
      if ($urandom_range(0, 1)) query_buf.push_back(rand_hex());
    end else if ($urandom_range(0, 9) == 0) begin
      query_buf.push_back(uqp_pkg::CHAR_AMP);
    end
  endfunction

  // Send the built query, ending on its last byte or on an end-only item.
  task send_query();
    bit end_only;
    end_only = (query_buf.size() == 0) || ($urandom_range(0, 3) == 0);
    foreach (query_buf[i]) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(query_buf[i], 1'b1, !end_only && (i == query_buf.size() - 1));
    end
    if (end_only) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Main sequence.
  initial begin
    int qn;
    int mode;
    in_if.valid         <= 1'b0;
    in_if.byte_in       <= 8'h00;
    in_if.byte_present  <= 1'b0;
    in_if.end_of_string <= 1'b0;
    rst_ni       = 1'b1;
    tx_idle_en   = 1'b1;
    rx_idle_en   = 1'b1;
    hold_request = 1'b0;
    items_sent   = 0;
    // Give reset a clean falling edge so the asynchronous clear always fires.
    #1;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: byte extremes, both phases, a second equals sign in the value.
    send_item(8'h00, 1'b1, 1'b0);
    send_text("=", 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_text("=%4a+", 1'b0);
    // Part ends, an empty part, and a lone equals sign.
    send_text("&&=&", 1'b0);
    // Broken escapes: a non-hex byte, a second percent, a part end after one digit.
    send_text("%G%%4&", 1'b0);
    // Pending escape before the key's equals sign, and one left open at the end.
    send_text("%=%F", 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // Most results from one item: held escape, the byte and the pair end.
    send_text("%4x", 1'b1);
    // An empty item is ignored.
    send_item(8'hA5, 1'b0, 1'b0);

    // Random query strings under changing idle patterns.
    qn = 0;
    while (items_sent < 480) begin
      mode       = (qn / 6) % 4;
      tx_idle_en = (mode == 0) || (mode == 2);
      rx_idle_en = (mode == 0) || (mode == 3);
      if (qn == 30) hold_request = 1'b1;
      if (qn >= 30 && qn < 34) tx_idle_en = 1'b0;
      make_query();
      send_query();
      qn++;
    end
    in_if.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (board.fail_count == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### urlencoded_query_parser_top.f
rtl/core/uqp_pkg.sv
rtl/core/uqp_if.sv
rtl/core/uqp_front.sv
rtl/core/uqp_queue.sv
rtl/core/uqp_back.sv
rtl/core/urlencoded_query_parser_top.sv
rtl/core/uqp_checker.sv
tb/urlencoded_query_parser_top_tb.sv
